// ----- rtl/sit_pkg.sv -----
package sit_pkg;

  localparam int SESSIONS = 1024;
  localparam int ID_W     = $clog2(SESSIONS);
  localparam int LVL_W    = $clog2(SESSIONS + 1);

  localparam int CMD_W    = 2;
  localparam int SID_W    = 10;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOOKUP   = 3'd4;

  typedef struct packed {
    logic [IP_W-1:0]   my_ip;
    logic [IP_W-1:0]   their_ip;
    logic [PORT_W-1:0] my_port;
    logic [PORT_W-1:0] their_port;
  } tuple_t;

  typedef enum logic [1:0] {
    JOB_INSERT,
    JOB_RELEASE,
    JOB_LOOKUP
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic             in_range;
    logic [SID_W-1:0] sid;
    tuple_t           tuple;
  } job_t;

  function automatic logic [ID_W-1:0] sid_to_idx(logic [SID_W-1:0] s);
    logic [ID_W+SID_W-1:0] w;
    w = {{ID_W{1'b0}}, s};
    return w[ID_W-1:0];
  endfunction

  function automatic logic [SID_W-1:0] idx_to_sid(logic [ID_W-1:0] i);
    logic [ID_W+SID_W-1:0] w;
    w = {{SID_W{1'b0}}, i};
    return w[SID_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] next_idx(logic [ID_W-1:0] i);
    return (i == ID_W'(SESSIONS - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

// ----- rtl/sit_if.sv -----
interface sit_req_if;
  logic                         valid;
  logic                         ready;
  logic [sit_pkg::CMD_W-1:0]    cmd;
  logic [sit_pkg::SID_W-1:0]    session_id;
  logic [sit_pkg::IP_W-1:0]     my_ip;
  logic [sit_pkg::IP_W-1:0]     their_ip;
  logic [sit_pkg::PORT_W-1:0]   my_port;
  logic [sit_pkg::PORT_W-1:0]   their_port;

  modport source (output valid, cmd, session_id, my_ip, their_ip, my_port, their_port,
                  input ready);
  modport sink   (input valid, cmd, session_id, my_ip, their_ip, my_port, their_port,
                  output ready);
endinterface

interface sit_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sit_pkg::STATUS_W-1:0]  status;
  logic [sit_pkg::SID_W-1:0]     out_session_id;
  logic [sit_pkg::IP_W-1:0]      out_my_ip;
  logic [sit_pkg::IP_W-1:0]      out_their_ip;
  logic [sit_pkg::PORT_W-1:0]    out_my_port;
  logic [sit_pkg::PORT_W-1:0]    out_their_port;
  logic [sit_pkg::CNT_W-1:0]     used_count;
  logic [sit_pkg::CNT_W-1:0]     released_count;

  modport source (output valid, status, out_session_id, out_my_ip, out_their_ip,
                  out_my_port, out_their_port, used_count, released_count,
                  input ready);
  modport sink   (input valid, status, out_session_id, out_my_ip, out_their_ip,
                  out_my_port, out_their_port, used_count, released_count,
                  output ready);
endinterface

// ----- rtl/sit_front.sv -----
module sit_front (
  input  logic            clk,
  input  logic            rst,
  sit_req_if.sink         req,
  output sit_pkg::job_t   job,
  output logic            job_valid,
  input  logic            job_ready
);

  sit_pkg::job_t q [2];
  sit_pkg::job_t in_job;
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push;
  logic          pop;

  always_comb begin
    in_job.sid      = req.session_id;
    in_job.in_range = 32'(req.session_id) < 32'(sit_pkg::SESSIONS);
    in_job.tuple    = '{my_ip: req.my_ip, their_ip: req.their_ip,
                        my_port: req.my_port, their_port: req.their_port};
    case (req.cmd)
      sit_pkg::CMD_INSERT:  in_job.kind = sit_pkg::JOB_INSERT;
      sit_pkg::CMD_RELEASE: in_job.kind = sit_pkg::JOB_RELEASE;
      default:              in_job.kind = sit_pkg::JOB_LOOKUP;
    endcase
  end

  assign req.ready = (count != 2'd2);
  // unused command is taken and dropped here
  assign push      = req.valid && req.ready && (req.cmd != sit_pkg::CMD_NONE);
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count missed a push");

endmodule

// ----- rtl/sit_back.sv -----
module sit_back (
  input  logic            clk,
  input  logic            rst,
  input  sit_pkg::job_t   job,
  input  logic            job_valid,
  output logic            job_ready,
  sit_rsp_if.source       rsp
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  localparam int ID_W  = sit_pkg::ID_W;
  localparam int LVL_W = sit_pkg::LVL_W;

  sit_pkg::tuple_t   tuple_mem [sit_pkg::SESSIONS];
  logic              valid_mem [sit_pkg::SESSIONS];
  logic [ID_W-1:0]   free_mem  [sit_pkg::SESSIONS];

  state_t                       state;
  sit_pkg::job_t                cur;
  logic [ID_W-1:0]              head;
  logic [ID_W-1:0]              tail;
  logic                         head_wrapped;
  logic                         tail_wrapped;
  logic [LVL_W-1:0]             level;
  logic [sit_pkg::CNT_W-1:0]    used_total;
  logic [sit_pkg::CNT_W-1:0]    released_total;

  sit_pkg::tuple_t              rd_tuple;
  logic                         rd_valid_raw;
  logic                         rd_valid_seen;
  logic [ID_W-1:0]              rd_free_raw;
  logic                         rd_free_fresh;

  logic                         out_valid;
  logic [sit_pkg::STATUS_W-1:0] out_status;
  logic [sit_pkg::SID_W-1:0]    out_sid;
  sit_pkg::tuple_t              out_tuple;

  logic                         issue;
  logic                         exec;
  logic [ID_W-1:0]              job_idx;
  logic [ID_W-1:0]              cur_idx;
  logic [ID_W-1:0]              free_id;
  logic                         id_valid;
  logic                         alloc;
  logic                         release_ok;
  logic                         push_free;
  logic [sit_pkg::STATUS_W-1:0] res_status;
  logic [sit_pkg::SID_W-1:0]    res_sid;
  sit_pkg::tuple_t              res_tuple;
  logic [sit_pkg::CNT_W-1:0]    used_next;
  logic [sit_pkg::CNT_W-1:0]    released_next;

  assign job_ready = (state == ST_IDLE);
  assign issue     = job_valid && job_ready;
  assign exec      = (state == ST_EXEC) && (!out_valid || rsp.ready);
  assign job_idx   = sit_pkg::sid_to_idx(job.sid);
  assign cur_idx   = sit_pkg::sid_to_idx(cur.sid);

  // entries never written: free list holds its own index, marks read as cleared
  assign free_id  = rd_free_fresh ? head : rd_free_raw;
  assign id_valid = rd_valid_seen && rd_valid_raw;

  always_comb begin
    alloc         = 1'b0;
    release_ok    = 1'b0;
    push_free     = 1'b0;
    res_status    = sit_pkg::ST_LOOKUP;
    res_sid       = cur.sid;
    res_tuple     = '0;
    used_next     = used_total;
    released_next = released_total;
    case (cur.kind)
      sit_pkg::JOB_INSERT: begin
        if (level == '0) begin
          res_status = sit_pkg::ST_NO_FREE;
          res_sid    = '0;
        end else begin
          alloc      = 1'b1;
          res_status = sit_pkg::ST_INSERTED;
          res_sid    = sit_pkg::idx_to_sid(free_id);
          used_next  = used_total + 1'b1;
        end
      end
      sit_pkg::JOB_RELEASE: begin
        if (id_valid) begin
          release_ok    = 1'b1;
          push_free     = (level < LVL_W'(sit_pkg::SESSIONS));
          res_status    = sit_pkg::ST_RELEASED;
          res_tuple     = rd_tuple;
          used_next     = used_total - 1'b1;
          released_next = released_total + 1'b1;
        end else begin
          res_status = sit_pkg::ST_INVALID;
        end
      end
      default: begin
        res_status = sit_pkg::ST_LOOKUP;
        res_tuple  = cur.in_range ? rd_tuple : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_tuple     <= tuple_mem[job_idx];
      rd_valid_raw <= valid_mem[job_idx];
      rd_free_raw  <= free_mem[head];
    end
    if (exec && alloc) begin
      tuple_mem[free_id] <= cur.tuple;
      valid_mem[free_id] <= 1'b1;
    end else if (exec && release_ok) begin
      valid_mem[cur_idx] <= 1'b0;
    end
    if (exec && push_free) begin
      free_mem[tail] <= cur_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur           <= job;
      rd_valid_seen <= job.in_range && (head_wrapped || job_idx < head);
      rd_free_fresh <= !tail_wrapped && (head >= tail);
    end
    if (exec) begin
      out_status <= res_status;
      out_sid    <= res_sid;
      out_tuple  <= res_tuple;
    end
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      tail           <= '0;
      head_wrapped   <= 1'b0;
      tail_wrapped   <= 1'b0;
      level          <= LVL_W'(sit_pkg::SESSIONS);
      used_total     <= '0;
      released_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (issue) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (exec) begin
        out_valid      <= 1'b1;
        used_total     <= used_next;
        released_total <= released_next;
        if (alloc) begin
          head  <= sit_pkg::next_idx(head);
          level <= level - 1'b1;
          if (head == ID_W'(sit_pkg::SESSIONS - 1)) begin
            head_wrapped <= 1'b1;
          end
        end
        if (push_free) begin
          tail  <= sit_pkg::next_idx(tail);
          level <= level + 1'b1;
          if (tail == ID_W'(sit_pkg::SESSIONS - 1)) begin
            tail_wrapped <= 1'b1;
          end
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.out_session_id = out_sid;
  assign rsp.out_my_ip      = out_tuple.my_ip;
  assign rsp.out_their_ip   = out_tuple.their_ip;
  assign rsp.out_my_port    = out_tuple.my_port;
  assign rsp.out_their_port = out_tuple.their_port;
  assign rsp.used_count     = used_total;
  assign rsp.released_count = released_total;

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(sit_pkg::SESSIONS))
    else $error("free list level above capacity");
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (32'(used_total) + 32'(level)) == 32'(sit_pkg::SESSIONS))
    else $error("used count and free list disagree");
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    exec |=> (out_valid && state == ST_IDLE))
    else $error("executed item did not reach output register");

endmodule

// ----- rtl/session_id_table.sv -----
// channel | dir | handshake   | payload
// req     | in  | valid/ready | cmd, session_id, my_ip, their_ip, my_port, their_port
// rsp     | out | valid/ready | status, out_session_id, out_my_* / out_their_*, counts
//
// Each item: registered read of the tuple, mark and free list memories, then one
// execute step that writes back and loads the output register; no new item until then.
// A two-entry queue lets req keep being accepted, until it is full, while the back end works or rsp stalls.
// Synchronous reset; no clearing pass, marks and free list are covered by head/tail pointers and wrap flags.
// cmd 3 is accepted and dropped without a result.
module session_id_table (
  input logic     clk,
  input logic     rst,
  sit_req_if.sink req,
  sit_rsp_if.source rsp
);

  sit_pkg::job_t job;
  logic          job_valid;
  logic          job_ready;

  sit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  sit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .rsp       (rsp)
  );

endmodule
